@@ sv/oaht_pkg.sv @@
// package: types and codes for the open addressing hash table
`timescale 1ns / 1ps
`default_nettype none
package oaht_pkg;
	localparam logic [1:0] OP_FIND     = 2'd0;
	localparam logic [1:0] OP_INSERT   = 2'd1;
	localparam logic [1:0] OP_DELETE   = 2'd2;
	localparam logic [1:0] OP_RESERVED = 2'd3;

	localparam logic [2:0] ST_FOUND     = 3'd0;
	localparam logic [2:0] ST_INSERTED  = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_DELETED   = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	localparam logic [1:0] MARK_EMPTY   = 2'd0;
	localparam logic [1:0] MARK_VALID   = 2'd1;
	localparam logic [1:0] MARK_DELETED = 2'd2;

	localparam logic [10:0] COUNT_MAX = 11'd2047;

	localparam int CFG_AW = 3;
	localparam logic [CFG_AW-1:0] REG_TABLE_SIZE   = 3'd0;
	localparam logic [CFG_AW-1:0] REG_MAX_OCCUPIED = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_MOD,
		S_READ,
		S_WAIT,
		S_CHECK,
		S_STEP,
		S_COMMIT,
		S_OUT
	} state_t;
endpackage
`default_nettype wire

@@ sv/oaht_if.sv @@
// valid/ready channel interfaces for request and result words
`timescale 1ns / 1ps
`default_nettype none
interface oaht_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] hash_value;
	logic [31:0] key;
	modport source (output valid, operation, hash_value, key, input ready);
	modport sink (input valid, operation, hash_value, key, output ready);
endinterface

interface oaht_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [9:0] slot_index;
	modport source (output valid, status, slot_index, input ready);
	modport sink (input valid, status, slot_index, output ready);
endinterface
`default_nettype wire

@@ sv/open_addressing_hash_table.sv @@
// top level: open addressing hash table with quadratic probing and tombstones
// channel  dir  payload                      handshake
// req      in   operation, hash_value, key   valid/ready
// rsp      out  status, slot_index           valid/ready
// apb      in   table_size, max_occupied     psel/penable/pwrite
// a request is accepted in S_IDLE, then runs restoring modulo (one quotient bit a cycle
// through one subtract/compare), then reads, waits on and checks each probed slot, with
// a step between slots, then commits and finishes; the probe count is at most the
// effective table size (table_size clamped to 1..MAX_SLOTS)
// after reset a clearing pass marks every slot empty; no request is taken until it ends
// one request at a time; the result register holds while rsp is stalled
`timescale 1ns / 1ps
`default_nettype none
module open_addressing_hash_table #(
	parameter int MAX_SLOTS = 1024,
	parameter int KEY_BITS  = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	oaht_req_if.sink                         req,
	oaht_rsp_if.source                       rsp,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire [oaht_pkg::CFG_AW-1:0]       paddr,
	input  wire [31:0]                       pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import oaht_pkg::*;

	localparam int AW = $clog2(MAX_SLOTS);
	localparam int SW = AW + 1;
	localparam logic [SW-1:0] MAX_SIZE = SW'(MAX_SLOTS);
	localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_SLOTS - 1);

	state_t state_q, state_d;

	logic [10:0] table_size_q;
	logic [9:0]  max_occupied_q;
	logic [10:0] occupied_q, deleted_q;

	logic [1:0]  op_q;
	logic [31:0] hash_q;
	logic [KEY_BITS-1:0] key_q;
	logic [SW-1:0] siz_q;
	logic [SW:0]   rem_q;
	logic [5:0]    bit_q;
	logic [SW:0]   hk_q;
	logic [SW:0]   incr_q;
	logic [SW-1:0] n_q;
	logic          have_del_q;
	logic [AW-1:0] del_q;
	logic [AW-1:0] clr_q;
	logic [2:0]    status_q;
	logic [9:0]    slot_q;
	logic          rsp_valid_q;
	logic          found_q;
	logic          has_cand_q;
	logic [AW-1:0] res_q;

	logic [AW-1:0] addr;
	logic          key_we, mark_we;
	logic [KEY_BITS-1:0] key_rd;
	logic [1:0]    mark_wd, mark_rd;
	logic [SW-1:0] siz_eff;
	logic [SW:0]   rem_sh, rem_sub;
	logic [SW:0]   hk_a, hk_b, hk_c, incr_a;
	logic [SW:0]   hk_nx, incr_nx;
	logic          wr;
	logic [KEY_BITS-1:0] key_in;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign key_in = KEY_BITS'(req.key);

	always_comb begin
		case (paddr)
			REG_TABLE_SIZE:   prdata = {21'd0, table_size_q};
			REG_MAX_OCCUPIED: prdata = {22'd0, max_occupied_q};
			default:          prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q   <= 11'd1021;
			max_occupied_q <= 10'd893;
		end else if (wr) begin
			if (paddr == REG_TABLE_SIZE) begin
				table_size_q <= pwdata[10:0];
			end else if (paddr == REG_MAX_OCCUPIED) begin
				max_occupied_q <= pwdata[9:0];
			end
		end
	end

	always_comb begin
		if (table_size_q == 11'd0) begin
			siz_eff = SW'(1);
		end else if ({21'd0, table_size_q} > 32'(MAX_SLOTS)) begin
			siz_eff = MAX_SIZE;
		end else begin
			siz_eff = SW'(table_size_q);
		end
	end

	// restoring modulo, one hash bit a cycle
	assign rem_sh  = {rem_q[SW-1:0], hash_q[bit_q[4:0]]};
	assign rem_sub = rem_sh - {1'b0, siz_q};

	// probe step
	assign hk_a   = hk_q + incr_q;
	assign incr_a = (incr_q != (SW+1)'(2)) ? incr_q + (SW+1)'(2) : incr_q;
	assign hk_b   = hk_a - {1'b0, siz_q};
	assign hk_c   = hk_b - {1'b0, siz_q};

	always_comb begin
		hk_nx   = hk_a;
		incr_nx = incr_a;
		if (!hk_b[SW]) begin
			hk_nx = hk_c[SW] ? hk_b : hk_c;
			if (incr_a >= {1'b0, siz_q}) incr_nx = (SW+1)'(2);
		end
	end

	oaht_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_SLOTS)) u_keys (
		.clk(clk), .we(key_we), .addr(addr), .wdata(key_q), .rdata(key_rd)
	);
	oaht_ram #(.WIDTH(2), .DEPTH(MAX_SLOTS)) u_marks (
		.clk(clk), .we(mark_we), .addr(addr), .wdata(mark_wd), .rdata(mark_rd)
	);

	logic commit_ins, commit_del;

	// walk decisions in S_CHECK
	logic hit_now, empty_now, guard_end;
	assign hit_now   = (mark_rd == MARK_VALID) && (key_rd == key_q);
	assign empty_now = (mark_rd == MARK_EMPTY);
	assign guard_end = (n_q + SW'(1) >= siz_q);

	always_comb begin
		state_d    = state_q;
		addr       = hk_q[AW-1:0];
		key_we     = 1'b0;
		mark_we    = 1'b0;
		mark_wd    = MARK_EMPTY;
		req.ready  = 1'b0;
		commit_ins = 1'b0;
		commit_del = 1'b0;
		case (state_q)
			S_CLEAR: begin
				addr    = clr_q;
				mark_we = 1'b1;
				if (clr_q == LAST_SLOT) state_d = S_IDLE;
			end
			S_IDLE: begin
				req.ready = !rsp_valid_q;
				if (req.valid && !rsp_valid_q) state_d = S_MOD;
			end
			S_MOD: begin
				if (bit_q == 6'd0) state_d = S_READ;
			end
			S_READ:  state_d = S_WAIT;
			S_WAIT:  state_d = S_CHECK;
			S_CHECK: begin
				if (hit_now || empty_now || guard_end) state_d = S_COMMIT;
				else state_d = S_STEP;
			end
			S_STEP:  state_d = S_READ;
			S_COMMIT: begin
				addr = res_q;
				state_d = S_OUT;
				if (op_q == OP_INSERT && !found_q && has_cand_q
				    && occupied_q < {1'b0, max_occupied_q}) begin
					commit_ins = 1'b1;
					key_we  = 1'b1;
					mark_we = 1'b1;
					mark_wd = MARK_VALID;
				end else if (op_q == OP_DELETE && found_q) begin
					commit_del = 1'b1;
					mark_we = 1'b1;
					mark_wd = MARK_DELETED;
				end
			end
			S_OUT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	logic cand_del_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			occupied_q  <= '0;
			deleted_q   <= '0;
		end else begin
			state_q <= state_d;
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: clr_q <= clr_q + AW'(1);
				S_IDLE: begin
					if (req.valid && !rsp_valid_q) begin
						op_q       <= req.operation;
						hash_q     <= req.hash_value;
						key_q      <= key_in;
						siz_q      <= siz_eff;
						rem_q      <= '0;
						bit_q      <= 6'd31;
						have_del_q <= 1'b0;
						del_q      <= '0;
						n_q        <= '0;
						incr_q     <= (SW+1)'(1);
						found_q    <= 1'b0;
						has_cand_q <= 1'b0;
						res_q      <= '0;
						cand_del_q <= 1'b0;
					end
				end
				S_MOD: begin
					if (!rem_sub[SW]) rem_q <= rem_sub;
					else rem_q <= rem_sh;
					bit_q <= bit_q - 6'd1;
					if (bit_q == 6'd0) begin
						hk_q <= rem_sub[SW] ? rem_sh : rem_sub;
					end
				end
				S_CHECK: begin
					if (hit_now) begin
						found_q <= 1'b1;
						res_q   <= hk_q[AW-1:0];
					end else if (empty_now) begin
						has_cand_q <= 1'b1;
						res_q      <= have_del_q ? del_q : hk_q[AW-1:0];
						cand_del_q <= have_del_q;
					end else begin
						if (mark_rd != MARK_VALID && !have_del_q) begin
							have_del_q <= 1'b1;
							del_q      <= hk_q[AW-1:0];
						end
						if (guard_end) begin
							has_cand_q <= have_del_q || (mark_rd != MARK_VALID);
							res_q      <= have_del_q ? del_q :
							              ((mark_rd != MARK_VALID) ? hk_q[AW-1:0] : '0);
							cand_del_q <= have_del_q || (mark_rd != MARK_VALID);
						end
					end
				end
				S_STEP: begin
					n_q    <= n_q + SW'(1);
					incr_q <= incr_nx;
					hk_q   <= hk_nx;
				end
				S_COMMIT: begin
					rsp_valid_q <= 1'b1;
					slot_q <= 10'(res_q);
					if (found_q) begin
						status_q <= (op_q == OP_DELETE) ? ST_DELETED : ST_FOUND;
					end else if (op_q == OP_INSERT) begin
						status_q <= commit_ins ? ST_INSERTED : ST_FULL;
					end else begin
						status_q <= ST_NOT_FOUND;
					end
					if (commit_ins) begin
						if (cand_del_q) begin
							if (deleted_q != 11'd0) deleted_q <= deleted_q - 11'd1;
						end else if (occupied_q < COUNT_MAX) begin
							occupied_q <= occupied_q + 11'd1;
						end
					end
					if (commit_del && deleted_q < COUNT_MAX) deleted_q <= deleted_q + 11'd1;
				end
				default: ;
			endcase
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.slot_index = slot_q;
endmodule
`default_nettype wire

@@ sv/oaht_ram.sv @@
// generic single port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module oaht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] addr,
	input  wire [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire
